FILE: hdl/la8tbd_pkg.sv
// Shared types, constants and helpers for the LA8 texture block decoder.
// Has no dependencies; every other file of the block imports it.
package la8tbd_pkg;

  localparam int unsigned PixW  = 16;
  localparam int unsigned ChW   = 8;
  localparam int unsigned IdxW  = 32;
  localparam int unsigned RowW  = 2;
  localparam int unsigned SelW  = 2;
  localparam int unsigned NumPal = 4;

  localparam logic [ChW-1:0]  W_FOUR   = 8'd85;
  localparam logic [ChW-1:0]  W_THREE  = 8'd128;
  localparam logic [ChW-1:0]  CH_MAX   = 8'd255;
  localparam logic [RowW-1:0] ROW_LAST = 2'd3;

  // one decoded block: four palette entries and the raw index word
  typedef struct packed {
    logic [NumPal-1:0][PixW-1:0] pal;
    logic [IdxW-1:0]             idx;
  } blk_t;

  // queue status seen by each side
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // exact x / 255 for x up to 255 * 255
  function automatic logic [ChW-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

FILE: hdl/la8tbd_front.sv
// Front end: accepts a compressed block, forms the weighted channel sums,
// then divides by 255 and offers the finished palette to the queue. Uses la8tbd_pkg.
module la8tbd_front import la8tbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [PixW-1:0]  in_first_endpoint,
  input  logic [PixW-1:0]  in_second_endpoint,
  input  logic [IdxW-1:0]  in_index_bits,
  input  q_stat_t          q_stat,
  output logic             q_push,
  output blk_t             q_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  logic             four_r;
  logic [PixW-1:0]  e0_r, e1_r;
  logic [IdxW-1:0]  idx_r;
  logic [15:0]      s2_lum_r, s2_alp_r, s3_lum_r, s3_alp_r;

  logic             accept;
  logic             four;
  logic [ChW-1:0]   w2, w2_inv;
  logic [15:0]      s2_lum, s2_alp, s3_lum, s3_alp;

  assign q_push  = s1_valid_r && !q_stat.full;
  assign in_full = s1_valid_r && q_stat.full;
  assign accept  = in_push && !in_full;

  // weights for the third entry follow the mode; the fourth is only used in four-colour mode
  always_comb begin
    four   = in_first_endpoint > in_second_endpoint;
    w2     = four ? W_FOUR : W_THREE;
    w2_inv = CH_MAX - w2;
    s2_lum = 16'(in_first_endpoint[7:0])   * 16'(w2_inv)
           + 16'(in_second_endpoint[7:0])  * 16'(w2);
    s2_alp = 16'(in_first_endpoint[15:8])  * 16'(w2_inv)
           + 16'(in_second_endpoint[15:8]) * 16'(w2);
    s3_lum = 16'(in_second_endpoint[7:0])  * 16'(CH_MAX - W_FOUR)
           + 16'(in_first_endpoint[7:0])   * 16'(W_FOUR);
    s3_alp = 16'(in_second_endpoint[15:8]) * 16'(CH_MAX - W_FOUR)
           + 16'(in_first_endpoint[15:8])  * 16'(W_FOUR);
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      four_r   <= four;
      e0_r     <= in_first_endpoint;
      e1_r     <= in_second_endpoint;
      idx_r    <= in_index_bits;
      s2_lum_r <= s2_lum;
      s2_alp_r <= s2_alp;
      s3_lum_r <= s3_lum;
      s3_alp_r <= s3_alp;
    end
  end

  // finish the blends: truncating divide by 255
  always_comb begin
    q_wdata.pal[0] = e0_r;
    q_wdata.pal[1] = e1_r;
    q_wdata.pal[2] = {div255(s2_alp_r), div255(s2_lum_r)};
    q_wdata.pal[3] = four_r ? {div255(s3_alp_r), div255(s3_lum_r)} : '0;
    q_wdata.idx    = idx_r;
  end

endmodule

FILE: hdl/la8tbd_queue.sv
// Short queue of decoded palettes between the front and back ends.
// Uses la8tbd_pkg for the entry type.
module la8tbd_queue import la8tbd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  blk_t    wdata,
  input  logic    pop,
  output blk_t    rdata,
  output q_stat_t stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  blk_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign stat.full  = count_r == CntW'(DEPTH);
  assign stat.empty = count_r == '0;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/la8tbd_back.sv
// Back end: walks the four rows of the head block, one row a beat, into
// the output register. Uses la8tbd_pkg.
module la8tbd_back import la8tbd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  blk_t             q_rdata,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [RowW-1:0]  out_row_number,
  output logic [PixW-1:0]  out_pixel_zero,
  output logic [PixW-1:0]  out_pixel_one,
  output logic [PixW-1:0]  out_pixel_two,
  output logic [PixW-1:0]  out_pixel_three,
  output logic             out_last_row
);

  logic                       out_valid_r, out_valid_nxt;
  logic [RowW-1:0]            row_r, row_nxt;
  logic                       load;
  logic [7:0]                 row_byte;
  logic [3:0][PixW-1:0]       pix;

  assign load      = !q_stat.empty && (!out_valid_r || out_pop);
  assign q_pop     = load && (row_r == ROW_LAST);
  assign out_empty = !out_valid_r;

  always_comb begin
    case (row_r)
      2'd0:    row_byte = q_rdata.idx[7:0];
      2'd1:    row_byte = q_rdata.idx[15:8];
      2'd2:    row_byte = q_rdata.idx[23:16];
      default: row_byte = q_rdata.idx[31:24];
    endcase
    for (int x = 0; x < 4; x++) begin
      pix[x] = q_rdata.pal[row_byte[2*x +: SelW]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    row_nxt       = row_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      row_nxt       = row_r + 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_number  <= row_r;
      out_pixel_zero  <= pix[0];
      out_pixel_one   <= pix[1];
      out_pixel_two   <= pix[2];
      out_pixel_three <= pix[3];
      out_last_row    <= row_r == ROW_LAST;
    end
  end

endmodule

FILE: hdl/la8_texture_block_decoder_unit.sv
// Top level of the LA8 texture block decoder: front end, palette queue, back end.
// Depends on la8tbd_pkg, la8tbd_front, la8tbd_queue and la8tbd_back.
//
//   channel  direction  handshake        payload
//   in_      in         in_push/in_full  first_endpoint, second_endpoint, index_bits
//   out_     out        out_pop/out_empty row_number, pixel_zero..three, last_row
//
// A block takes four beats on the output, one row a beat; the back end's row
// walker sets the sustained block rate, and a held-off out_pop stalls it.
// From an accepted push to the first row on the outputs, the weighted sums are
// registered in the front stage, divided and written into the queue, and then
// loaded by the back end into the output register; stalls can hold each step.
// Reset (synchronous, rst_n low) empties the front stage, queue and output register.
// A stalled output holds the current row; the queue then fills and in_full rises.
module la8_texture_block_decoder_unit import la8tbd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [PixW-1:0]  in_first_endpoint,
  input  logic [PixW-1:0]  in_second_endpoint,
  input  logic [IdxW-1:0]  in_index_bits,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [RowW-1:0]  out_row_number,
  output logic [PixW-1:0]  out_pixel_zero,
  output logic [PixW-1:0]  out_pixel_one,
  output logic [PixW-1:0]  out_pixel_two,
  output logic [PixW-1:0]  out_pixel_three,
  output logic             out_last_row
);

  q_stat_t q_stat;
  logic    q_push, q_pop;
  blk_t    q_wdata, q_rdata;

  // classify the block and build its palette
  la8tbd_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_first_endpoint  (in_first_endpoint),
    .in_second_endpoint (in_second_endpoint),
    .in_index_bits      (in_index_bits),
    .q_stat             (q_stat),
    .q_push             (q_push),
    .q_wdata            (q_wdata)
  );

  // decouple front and back so each stalls on its own
  la8tbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // expand the head block into four row beats
  la8tbd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_row_number  (out_row_number),
    .out_pixel_zero  (out_pixel_zero),
    .out_pixel_one   (out_pixel_one),
    .out_pixel_two   (out_pixel_two),
    .out_pixel_three (out_pixel_three),
    .out_last_row    (out_last_row)
  );

endmodule
